### rtl/octave_value_noise_2d_macros.svh
// Assertion macros shared by the octave value noise RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef OCTAVE_VALUE_NOISE_2D_MACROS_SVH
`define OCTAVE_VALUE_NOISE_2D_MACROS_SVH

// Condition implies consequence in the same cycle.
`define OVN_ASSERT_NOW(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the next cycle.
`define OVN_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ovn_pkg.sv
// Package for the octave value noise block: request codes, configuration indices and fixed widths.
// Depends on nothing.
package ovn_pkg;

  localparam int SEED_W   = 16;
  localparam int TRACK_W  = 18;
  localparam int WEIGHT_W = 32;
  localparam int ACC_W    = 56;
  localparam int WSUM_W   = 36;

  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_EVAL    = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  localparam logic [0:0] CFG_OCTAVES = 1'b0;
  localparam logic [0:0] CFG_PERSIST = 1'b1;

  localparam logic [TRACK_W-1:0] TRACK_LOW_RESET = 18'd131072;

  typedef logic [SEED_W-1:0] seed_t;
  typedef logic [TRACK_W-1:0] track_t;

endpackage

### rtl/octave_value_noise_2d.sv
// Octave value noise over a square seed grid held in a dual read port memory.
// An evaluation runs seed reads and blends for each octave, a bit-serial weight division between
// octaves, and then a final bit-serial division of the weighted sum by the sum of the weights.
// Load and restart requests are taken in the idle state. One item is in work at a time; a finished
// result waits in the output register, and a second one stalls the block and its input.
// Reset (rst_n, synchronous, active low) sets octave_count 4, divisor 8192, tracking 2.0 and 0;
// the seed memory is not cleared and must be loaded before it is evaluated. SIDE: power of two.
`include "octave_value_noise_2d_macros.svh"
module octave_value_noise_2d #(
  parameter int SIDE = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [15:0]           cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_req_type,
  input  logic [5:0]            in_col,
  input  logic [5:0]            in_row,
  input  ovn_pkg::seed_t        in_seed_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ovn_pkg::seed_t        out_noise_out,
  output ovn_pkg::track_t       out_lowest_out,
  output ovn_pkg::track_t       out_highest_out,
  output ovn_pkg::track_t       out_midpoint_out
);
  import ovn_pkg::*;

  localparam int AW   = $clog2(SIDE);
  localparam int CW   = (AW > 6) ? AW : 6;
  localparam int SW   = $clog2(AW + 1) > 0 ? $clog2(AW + 1) : 1;
  localparam int PW   = AW + 1;
  localparam int TW   = SEED_W + PW + 1;
  localparam int NW   = TW + PW + 1;
  localparam int OW   = 4;
  localparam logic [OW-1:0] OCT_LIM = OW'(AW + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDAB = 4'd1;
  localparam logic [3:0] S_RDCD = 4'd2;
  localparam logic [3:0] S_BOT  = 4'd3;
  localparam logic [3:0] S_NUM  = 4'd4;
  localparam logic [3:0] S_SMP  = 4'd5;
  localparam logic [3:0] S_MAC  = 4'd6;
  localparam logic [3:0] S_WDIV = 4'd7;
  localparam logic [3:0] S_FLD  = 4'd8;
  localparam logic [3:0] S_FDIV = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  seed_t seed_mem [SIDE*SIDE];

  logic [3:0]          state_r, state_nxt;
  logic [2:0]          oct_cfg_r;
  logic [15:0]         div_cfg_r;
  logic [AW-1:0]       x_r, y_r;
  logic [OW-1:0]       j_r, oct_r;
  logic [WEIGHT_W-1:0] weight_r;
  logic [ACC_W-1:0]    acc_r;
  logic [WSUM_W-1:0]   wsum_r;
  logic [TW-1:0]       top_r, bot_r;
  logic [NW-1:0]       num_r;
  seed_t               smp_r, res_r;
  seed_t               rd0_r, rd1_r;
  logic [ACC_W-1:0]    q_r;
  logic [WSUM_W-1:0]   rem_r, den_r;
  logic [5:0]          dcnt_r;
  track_t              low_r, high_r;
  logic                out_valid_r;
  seed_t               out_noise_r;
  track_t              out_low_r, out_high_r, out_mid_r;

  logic [CW-1:0]       col_w, row_w;
  logic [SW-1:0]       sh;
  logic [PW-1:0]       pm, msk, p_dx, p_dy, dxw, dyw;
  logic [AW-1:0]       x1, y1, x2, y2;
  logic [2*AW-1:0]     addr0, addr1;
  logic                rd_en;
  logic [WSUM_W:0]     rs;
  logic                qbit;
  logic [ACC_W-1:0]    q_nxt;
  logic [WSUM_W-1:0]   rem_nxt;
  logic [OW-1:0]       oct_eff;
  logic [47:0]         mac_prod;
  seed_t               final_val;
  track_t              new_low, new_high, new_mid;
  logic                accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign col_w    = CW'(in_col);
  assign row_w    = CW'(in_row);

  // Cell geometry for the current octave; pitch is a power of two.
  always_comb begin
    sh    = SW'(AW - int'(j_r));
    pm    = PW'(1) << sh;
    msk   = pm - PW'(1);
    dxw   = PW'(x_r) & msk;
    dyw   = PW'(y_r) & msk;
    p_dx  = pm - dxw;
    p_dy  = pm - dyw;
    x1    = x_r & ~msk[AW-1:0];
    y1    = y_r & ~msk[AW-1:0];
    x2    = AW'(PW'(x1) + pm);
    y2    = AW'(PW'(y1) + pm);
    rd_en = (state_r == S_RDAB) || (state_r == S_RDCD);
    if (state_r == S_RDAB) begin
      addr0 = {y1, x1};
      addr1 = {y1, x2};
    end else begin
      addr0 = {y2, x1};
      addr1 = {y2, x2};
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_req_type == REQ_LOAD) begin
      seed_mem[{row_w[AW-1:0], col_w[AW-1:0]}] <= in_seed_value;
    end
    if (rd_en) begin
      rd0_r <= seed_mem[addr0];
      rd1_r <= seed_mem[addr1];
    end
  end

  // One restoring division step per cycle.
  always_comb begin
    rs      = {rem_r, q_r[ACC_W-1]};
    qbit    = (rs >= {1'b0, den_r});
    rem_nxt = qbit ? WSUM_W'(rs - {1'b0, den_r}) : rs[WSUM_W-1:0];
    q_nxt   = {q_r[ACC_W-2:0], qbit};
  end

  always_comb begin
    if (oct_cfg_r == 3'd0) begin
      oct_eff = OW'(1);
    end else if (OW'(oct_cfg_r) > OCT_LIM) begin
      oct_eff = OCT_LIM;
    end else begin
      oct_eff = OW'(oct_cfg_r);
    end
    mac_prod  = smp_r * weight_r;
    final_val = (q_r[ACC_W-1:SEED_W] != '0) ? '1 : q_r[SEED_W-1:0];
    new_low   = (TRACK_W'(res_r) < low_r) ? TRACK_W'(res_r) : low_r;
    new_high  = (TRACK_W'(res_r) > high_r) ? TRACK_W'(res_r) : high_r;
    new_mid   = (new_high >= new_low) ? new_low + ((new_high - new_low) >> 1) : new_low;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept && in_req_type == REQ_EVAL) state_nxt = S_RDAB;
      S_RDAB: state_nxt = S_RDCD;
      S_RDCD: state_nxt = S_BOT;
      S_BOT:  state_nxt = S_NUM;
      S_NUM:  state_nxt = S_SMP;
      S_SMP:  state_nxt = S_MAC;
      S_MAC:  state_nxt = (j_r == oct_r - OW'(1)) ? S_FLD : S_WDIV;
      S_WDIV: if (dcnt_r == 6'd1) state_nxt = S_RDAB;
      S_FLD:  state_nxt = S_FDIV;
      S_FDIV: if (dcnt_r == 6'd1) state_nxt = S_FIN;
      S_FIN:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      oct_cfg_r   <= 3'd4;
      div_cfg_r   <= 16'd8192;
      low_r       <= TRACK_LOW_RESET;
      high_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_OCTAVES: oct_cfg_r <= cfg_wdata[2:0];
          CFG_PERSIST: div_cfg_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept && in_req_type == REQ_RESTART) begin
        low_r  <= TRACK_LOW_RESET;
        high_r <= '0;
      end
      if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
        low_r       <= new_low;
        high_r      <= new_high;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        x_r      <= col_w[AW-1:0];
        y_r      <= row_w[AW-1:0];
        j_r      <= '0;
        oct_r    <= oct_eff;
        weight_r <= WEIGHT_W'(65536);
        acc_r    <= '0;
        wsum_r   <= '0;
      end
      S_RDCD: top_r <= TW'(rd0_r) * TW'(p_dx) + TW'(rd1_r) * TW'(dxw);
      S_BOT:  bot_r <= TW'(rd0_r) * TW'(p_dx) + TW'(rd1_r) * TW'(dxw);
      S_NUM:  num_r <= NW'(top_r) * NW'(p_dy) + NW'(bot_r) * NW'(dyw);
      S_SMP:  smp_r <= SEED_W'(num_r >> {sh, 1'b0});
      S_MAC: begin
        acc_r  <= acc_r + ACC_W'(mac_prod);
        wsum_r <= wsum_r + WSUM_W'(weight_r);
        q_r    <= {weight_r, 24'd0};
        rem_r  <= '0;
        den_r  <= WSUM_W'((div_cfg_r == 16'd0) ? 16'd1 : div_cfg_r);
        dcnt_r <= 6'd44;
      end
      S_WDIV: begin
        q_r    <= q_nxt;
        rem_r  <= rem_nxt;
        dcnt_r <= dcnt_r - 6'd1;
        if (dcnt_r == 6'd1) begin
          weight_r <= (q_nxt[43:32] != '0) ? '1 : q_nxt[31:0];
          j_r      <= j_r + OW'(1);
        end
      end
      S_FLD: begin
        q_r    <= acc_r;
        rem_r  <= '0;
        den_r  <= wsum_r;
        dcnt_r <= 6'd56;
      end
      S_FDIV: begin
        q_r    <= q_nxt;
        rem_r  <= rem_nxt;
        dcnt_r <= dcnt_r - 6'd1;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_noise_r <= res_r;
          out_low_r   <= new_low;
          out_high_r  <= new_high;
          out_mid_r   <= new_mid;
        end
      end
      default: ;
    endcase
    if (state_r == S_FDIV && dcnt_r == 6'd1) res_r <= (q_nxt[ACC_W-1:SEED_W] != '0) ? '1 :
                                                      q_nxt[SEED_W-1:0];
  end

  assign out_valid        = out_valid_r;
  assign out_noise_out    = out_noise_r;
  assign out_lowest_out   = out_low_r;
  assign out_highest_out  = out_high_r;
  assign out_midpoint_out = out_mid_r;

  `OVN_ASSERT_NOW(a_low_le_high, clk, rst_n, out_valid_r, out_low_r <= out_high_r,
                  "low above high")
  `OVN_ASSERT_NOW(a_noise_in_range, clk, rst_n, out_valid_r,
                  TRACK_W'(out_noise_r) >= out_low_r && TRACK_W'(out_noise_r) <= out_high_r,
                  "noise outside tracked range")
  `OVN_ASSERT_NOW(a_octave_bound, clk, rst_n, state_r == S_MAC,
                  j_r < oct_r && oct_r <= OCT_LIM, "octave index out of range")
  `OVN_ASSERT_NEXT(a_div_done, clk, rst_n, state_r == S_FDIV && dcnt_r == 6'd1,
                   state_r == S_FIN && final_val == res_r, "final quotient lost")

endmodule
